FILE: hw/rtl/smwb_pkg.sv
// Package with the shared types and codes of the merging write buffer.
`timescale 1ns / 1ps
package smwb_pkg;

  localparam int unsigned SectorW = 31;
  localparam int unsigned LenW    = 16;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatW   = 2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TOOBIG  = 2'd1,
    STAT_ZEROLEN = 2'd2,
    STAT_RSVD    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_FLUSH = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef enum logic {
    REG_BUFFER_SECTORS = 1'b0,
    REG_MAX_MERGE      = 1'b1
  } reg_e;

  // Classified command passed from the front to the back.
  typedef struct packed {
    func_e                func;
    logic [SectorW-1:0]   start;
    logic [LenW-1:0]      count;
    logic                 reject;
    status_e              status;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    kind_e                kind;
    logic [SectorW-1:0]   sector;
    logic [LenW-1:0]      length;
    status_e              status;
    logic                 last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WFREE,
    ST_WMERGE,
    ST_WFULL,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/smwb_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module smwb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [smwb_pkg::FuncW-1:0]    func_i,
  input  logic [smwb_pkg::SectorW-1:0]  start_sector_i,
  input  logic [smwb_pkg::LenW-1:0]     sector_count_i,
  input  logic [smwb_pkg::LenW-1:0]     buffer_sectors_i,
  output logic                          cmd_valid_o,
  output smwb_pkg::cmd_t                cmd_o,
  input  logic                          cmd_take_i
);

  smwb_pkg::cmd_t q0_q, q0_d, q1_q, q1_d;
  logic [1:0]     cnt_q, cnt_d;
  smwb_pkg::cmd_t cls;
  logic           acc;

  // Classify the incoming write: zero length and oversize are rejected.
  always_comb begin
    cls.func   = smwb_pkg::func_e'(func_i);
    cls.start  = start_sector_i;
    cls.count  = sector_count_i;
    cls.reject = 1'b0;
    cls.status = smwb_pkg::STAT_OK;
    if (cls.func == smwb_pkg::FUNC_WRITE) begin
      if (sector_count_i == '0) begin
        cls.reject = 1'b1;
        cls.status = smwb_pkg::STAT_ZEROLEN;
      end else if (sector_count_i > buffer_sectors_i) begin
        cls.reject = 1'b1;
        cls.status = smwb_pkg::STAT_TOOBIG;
      end
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign acc         = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q0_q;

  // Two-entry queue; slot 0 is the head.
  always_comb begin
    q0_d  = q0_q;
    q1_d  = q1_q;
    cnt_d = cnt_q;
    if (cmd_take_i && cnt_q != 2'd0) begin
      q0_d  = q1_q;
      cnt_d = cnt_d - 2'd1;
    end
    if (acc) begin
      if (cnt_d == 2'd0) q0_d = cls;
      else q1_d = cls;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

endmodule

FILE: hw/rtl/smwb_back.sv
// Back end: walks the extent table, emits flush and done beats.
`timescale 1ns / 1ps
module smwb_back #(
  parameter int unsigned ENTRY_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  smwb_pkg::cmd_t                cmd_i,
  output logic                          cmd_take_o,
  input  logic [smwb_pkg::LenW-1:0]     buffer_sectors_i,
  input  logic [smwb_pkg::LenW-1:0]     max_merge_i,
  output logic                          res_valid_o,
  output smwb_pkg::res_t                res_o,
  input  logic                          res_ready_i
);

  localparam int unsigned IdxW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(ENTRY_DEPTH + 1);
  localparam int unsigned UseW = smwb_pkg::LenW + CntW;
  localparam logic [CntW-1:0] Depth = CntW'(ENTRY_DEPTH);

  logic [smwb_pkg::SectorW-1:0] st_q [ENTRY_DEPTH];
  logic [smwb_pkg::LenW-1:0]    ln_q [ENTRY_DEPTH];

  smwb_pkg::state_e state_q, state_d;
  smwb_pkg::cmd_t   cur_q;
  logic [CntW-1:0]  cnt_q;
  logic [UseW-1:0]  used_q;
  logic [CntW-1:0]  idx_q;   // scan position, may run one past the last entry
  logic [IdxW-1:0]  idx_rd;  // scan position as a table index
  logic [IdxW-1:0]  sh_q;    // shift position
  logic [smwb_pkg::LenW-1:0] free;

  // Result register.
  logic             rv_q;
  smwb_pkg::res_t   r_q;
  logic             slot;

  assign slot        = !rv_q || res_ready_i;
  assign res_valid_o = rv_q;
  assign res_o       = r_q;
  assign idx_rd      = IdxW'(idx_q);

  // Free sectors, held at zero when over capacity.
  always_comb begin
    if (UseW'(buffer_sectors_i) > used_q)
      free = smwb_pkg::LenW'(UseW'(buffer_sectors_i) - used_q);
    else
      free = '0;
  end

  // Tail-entry and scan-entry views.
  logic [IdxW-1:0] tail;
  logic [smwb_pkg::SectorW:0] tail_end;
  logic [smwb_pkg::LenW:0]    merged_len;
  logic can_merge;
  logic [smwb_pkg::SectorW:0] rd_last, e_last;
  logic overlap;
  logic scan_in;

  assign tail       = IdxW'(cnt_q - 1'b1);
  assign tail_end   = {1'b0, st_q[tail]} + (smwb_pkg::SectorW+1)'(ln_q[tail]);
  assign merged_len = {1'b0, ln_q[tail]} + {1'b0, cur_q.count};
  assign can_merge  = (cnt_q != '0) && (tail_end == {1'b0, cur_q.start})
                      && (merged_len <= {1'b0, max_merge_i});
  assign rd_last    = {1'b0, cur_q.start} + (smwb_pkg::SectorW+1)'(cur_q.count) - 1'b1;
  assign e_last     = {1'b0, st_q[idx_rd]} + (smwb_pkg::SectorW+1)'(ln_q[idx_rd]) - 1'b1;
  assign scan_in    = (idx_q < cnt_q);
  assign overlap    = (ln_q[idx_rd] != '0) && ({1'b0, st_q[idx_rd]} <= rd_last)
                      && ({1'b0, cur_q.start} <= e_last);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smwb_pkg::ST_IDLE:
        if (cmd_valid_i) begin
          if (cmd_i.reject || cmd_i.func == smwb_pkg::FUNC_NONE)
            state_d = smwb_pkg::ST_DONE;
          else if (cmd_i.func == smwb_pkg::FUNC_WRITE)
            state_d = smwb_pkg::ST_WFREE;
          else if (cmd_i.func == smwb_pkg::FUNC_READ)
            state_d = (cmd_i.count == '0) ? smwb_pkg::ST_DONE : smwb_pkg::ST_SCAN;
          else
            state_d = smwb_pkg::ST_SCAN;
        end
      smwb_pkg::ST_WFREE:
        if (free >= cur_q.count || cnt_q == '0) state_d = smwb_pkg::ST_WMERGE;
        else if (slot) state_d = smwb_pkg::ST_SHIFT;
      smwb_pkg::ST_WMERGE:
        if (can_merge) state_d = smwb_pkg::ST_DONE;
        else if (cnt_q < Depth) state_d = smwb_pkg::ST_WFULL;
        else if (slot) state_d = smwb_pkg::ST_SHIFT;
      smwb_pkg::ST_WFULL:
        state_d = smwb_pkg::ST_DONE;
      smwb_pkg::ST_SCAN:
        if (!scan_in) state_d = smwb_pkg::ST_DONE;
        else if (cur_q.func == smwb_pkg::FUNC_FLUSH || overlap) begin
          if (slot) state_d = smwb_pkg::ST_SHIFT;
        end
      smwb_pkg::ST_SHIFT:
        if (CntW'(sh_q) + 1'b1 >= cnt_q) begin
          if (cur_q.func == smwb_pkg::FUNC_WRITE) state_d = smwb_pkg::ST_WFREE;
          else state_d = smwb_pkg::ST_SCAN;
        end
      smwb_pkg::ST_DONE:
        if (slot) state_d = smwb_pkg::ST_IDLE;
      default: state_d = smwb_pkg::ST_IDLE;
    endcase
  end

  // A flush is issued on the transition into the gap-closing shift.
  logic do_flush, do_done;
  assign do_flush = (state_d == smwb_pkg::ST_SHIFT) && (state_q != smwb_pkg::ST_SHIFT);
  assign do_done  = (state_q == smwb_pkg::ST_DONE) && slot;
  assign cmd_take_o = (state_q == smwb_pkg::ST_IDLE) && cmd_valid_i;

  logic [IdxW-1:0] fl_idx;
  assign fl_idx = (state_q == smwb_pkg::ST_SCAN) ? idx_rd : '0;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smwb_pkg::ST_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      idx_q   <= '0;
      sh_q    <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_flush || do_done) rv_q <= 1'b1;
      else if (res_ready_i) rv_q <= 1'b0;
      if (cmd_take_o) idx_q <= '0;
      if (do_flush) begin
        sh_q   <= fl_idx;
        used_q <= used_q - UseW'(ln_q[fl_idx]);
      end
      if (state_q == smwb_pkg::ST_SCAN && state_d == smwb_pkg::ST_SCAN && scan_in
          && !(cur_q.func == smwb_pkg::FUNC_FLUSH || overlap))
        idx_q <= idx_q + 1'b1;
      if (state_q == smwb_pkg::ST_SHIFT) begin
        sh_q <= sh_q + 1'b1;
        if (state_d != smwb_pkg::ST_SHIFT) cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == smwb_pkg::ST_WMERGE && can_merge)
        used_q <= used_q + UseW'(cur_q.count);
      if (state_q == smwb_pkg::ST_WFULL) begin
        cnt_q  <= cnt_q + 1'b1;
        used_q <= used_q + UseW'(cur_q.count);
      end
    end
  end

  // Table, command and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cur_q <= cmd_i;
    if (do_flush) begin
      r_q.kind   <= smwb_pkg::KIND_FLUSH;
      r_q.sector <= st_q[fl_idx];
      r_q.length <= ln_q[fl_idx];
      r_q.status <= smwb_pkg::STAT_OK;
      r_q.last   <= 1'b0;
    end else if (do_done) begin
      r_q.kind   <= smwb_pkg::KIND_DONE;
      r_q.sector <= '0;
      r_q.length <= '0;
      r_q.status <= cur_q.status;
      r_q.last   <= 1'b1;
    end
    if (state_q == smwb_pkg::ST_SHIFT && CntW'(sh_q) + 1'b1 < cnt_q) begin
      st_q[sh_q] <= st_q[IdxW'(sh_q + 1'b1)];
      ln_q[sh_q] <= ln_q[IdxW'(sh_q + 1'b1)];
    end
    if (state_q == smwb_pkg::ST_WMERGE && can_merge)
      ln_q[tail] <= merged_len[smwb_pkg::LenW-1:0];
    if (state_q == smwb_pkg::ST_WFULL) begin
      st_q[IdxW'(cnt_q)] <= cur_q.start;
      ln_q[IdxW'(cnt_q)] <= cur_q.count;
    end
  end

endmodule

FILE: hw/rtl/ssd_merging_write_buffer.sv
// Top level of the merging write buffer: configuration registers, front and back.
//
//  Channel  | Handshake       | Beat
//  ---------+-----------------+---------------------------------------------
//  input    | push / full     | func, start_sector, sector_count
//  result   | pop / empty     | kind, flush_sector, flush_length, status, last
//  config   | cfg_we_i        | cfg_index_i, cfg_data_i
//
// The back end takes one item at a time: it scans the table one entry per cycle and
// closes the gap behind each flushed entry with a shift; a stalled result holds it.
// A two-entry queue lets the front accept beats while the back end works.
// Reset clears the queue, the table count and the result register.
// A stalled result holds the back end, while the front keeps accepting into the queue until full.
`timescale 1ns / 1ps
module ssd_merging_write_buffer #(
  parameter int unsigned ENTRY_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [smwb_pkg::FuncW-1:0]    func_i,
  input  logic [smwb_pkg::SectorW-1:0]  start_sector_i,
  input  logic [smwb_pkg::LenW-1:0]     sector_count_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind_o,
  output logic [smwb_pkg::SectorW-1:0]  flush_sector_o,
  output logic [smwb_pkg::LenW-1:0]     flush_length_o,
  output logic [smwb_pkg::StatW-1:0]    status_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [smwb_pkg::LenW-1:0]     cfg_data_i
);

  logic [smwb_pkg::LenW-1:0] buf_q, merge_q;
  logic                      cmd_valid, cmd_take, res_valid;
  smwb_pkg::cmd_t            cmd;
  smwb_pkg::res_t            res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= smwb_pkg::LenW'(1024);
      merge_q <= smwb_pkg::LenW'(1024);
    end else if (cfg_we_i) begin
      unique case (smwb_pkg::reg_e'(cfg_index_i))
        smwb_pkg::REG_BUFFER_SECTORS: buf_q   <= cfg_data_i;
        smwb_pkg::REG_MAX_MERGE:      merge_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  smwb_front u_front (
    .clk_i, .rst_ni, .push, .full, .func_i, .start_sector_i, .sector_count_i,
    .buffer_sectors_i(buf_q), .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .cmd_take_i(cmd_take)
  );

  // Free space follows the capacity register combinationally in the back end.
  smwb_back #(.ENTRY_DEPTH(ENTRY_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .buffer_sectors_i(buf_q), .max_merge_i(merge_q),
    .res_valid_o(res_valid), .res_o(res), .res_ready_i(pop)
  );

  assign empty          = !res_valid;
  assign kind_o         = res.kind;
  assign flush_sector_o = res.sector;
  assign flush_length_o = res.length;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule

FILE: tb/ssd_merging_write_buffer_tb.sv
// Self-checking testbench of the merging write buffer, with a scoreboard class.
`timescale 1ns / 1ps
module ssd_merging_write_buffer_tb;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned Drain     = 600;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  logic [smwb_pkg::FuncW-1:0]     func_i;
  logic [smwb_pkg::SectorW-1:0]   start_sector_i;
  logic [smwb_pkg::LenW-1:0]      sector_count_i;
  logic                           empty;
  logic                           pop;
  logic                           kind_o;
  logic [smwb_pkg::SectorW-1:0]   flush_sector_o;
  logic [smwb_pkg::LenW-1:0]      flush_length_o;
  logic [smwb_pkg::StatW-1:0]     status_o;
  logic                           last_o;
  logic                           cfg_we_i;
  logic                           cfg_index_i;
  logic [smwb_pkg::LenW-1:0]      cfg_data_i;

  ssd_merging_write_buffer #(.ENTRY_DEPTH(Depth)) dut (
    .clk_i, .rst_ni, .push, .full, .func_i, .start_sector_i, .sector_count_i,
    .empty, .pop, .kind_o, .flush_sector_o, .flush_length_o, .status_o, .last_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // Extent table model and the store of expected result beats.
  class wbuf_scoreboard;
    bit [smwb_pkg::SectorW-1:0] ext_start[Depth];
    bit [smwb_pkg::LenW-1:0]    ext_len[Depth];
    int unsigned      n_ext;
    int unsigned      capacity;
    int unsigned      merge_max;
    int unsigned      free_cnt;
    smwb_pkg::res_t   expected_beats[$];
    int unsigned      errors;
    int unsigned      flushes_seen;
    int unsigned      dones_seen;

    function new();
      capacity  = 1024;
      merge_max = 1024;
      n_ext     = 0;
      free_cnt  = 1024;
      errors    = 0;
    endfunction

    function void recount_free();
      int unsigned used;
      used = 0;
      for (int i = 0; i < n_ext; i++) used += ext_len[i];
      free_cnt = (capacity > used) ? capacity - used : 0;
    endfunction

    function void add_beat(smwb_pkg::kind_e k, bit [smwb_pkg::SectorW-1:0] s,
                           bit [smwb_pkg::LenW-1:0] l, smwb_pkg::status_e st, bit lst);
      smwb_pkg::res_t r;
      r.kind   = k;
      r.sector = s;
      r.length = l;
      r.status = st;
      r.last   = lst;
      expected_beats.push_back(r);
    endfunction

    // Flush one entry and close the gap behind it.
    function void flush_at(int unsigned idx);
      add_beat(smwb_pkg::KIND_FLUSH, ext_start[idx], ext_len[idx], smwb_pkg::STAT_OK, 1'b0);
      for (int unsigned i = idx; i + 1 < n_ext; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i]   = ext_len[i+1];
      end
      n_ext--;
      recount_free();
    endfunction

    function void set_reg(smwb_pkg::reg_e r, bit [smwb_pkg::LenW-1:0] v);
      if (r == smwb_pkg::REG_BUFFER_SECTORS) begin
        capacity = v;
        recount_free();
      end else begin
        merge_max = v;
      end
    endfunction

    function void note_input(smwb_pkg::func_e f, bit [smwb_pkg::SectorW-1:0] s,
                             bit [smwb_pkg::LenW-1:0] c);
      smwb_pkg::status_e st;
      bit               merged;
      longint unsigned  tail_end;
      longint unsigned  rd_last;
      longint unsigned  e_last;
      int unsigned      i;
      st = smwb_pkg::STAT_OK;
      case (f)
        smwb_pkg::FUNC_WRITE: begin
          if (c == 0) begin
            st = smwb_pkg::STAT_ZEROLEN;
          end else if (c > capacity) begin
            st = smwb_pkg::STAT_TOOBIG;
          end else begin
            merged = 1'b0;
            while (free_cnt < c && n_ext > 0) flush_at(0);
            if (n_ext > 0) begin
              tail_end = longint'(ext_start[n_ext-1]) + ext_len[n_ext-1];
              if (tail_end == s && ext_len[n_ext-1] + c <= merge_max) begin
                ext_len[n_ext-1] += c;
                merged = 1'b1;
              end
            end
            if (!merged) begin
              if (n_ext >= Depth) flush_at(0);
              ext_start[n_ext] = s;
              ext_len[n_ext]   = c;
              n_ext++;
            end
            recount_free();
          end
        end
        smwb_pkg::FUNC_READ: begin
          if (c != 0) begin
            rd_last = longint'(s) + c - 1;
            i = 0;
            while (i < n_ext) begin
              e_last = longint'(ext_start[i]) + ext_len[i] - 1;
              if (ext_len[i] != 0 && ext_start[i] <= rd_last && s <= e_last) flush_at(i);
              else i++;
            end
          end
        end
        smwb_pkg::FUNC_FLUSH: begin
          while (n_ext > 0) flush_at(0);
        end
        default: ;
      endcase
      add_beat(smwb_pkg::KIND_DONE, '0, '0, st, 1'b1);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic k, logic [smwb_pkg::SectorW-1:0] s,
                      logic [smwb_pkg::LenW-1:0] l, logic [smwb_pkg::StatW-1:0] st,
                      logic lst);
      smwb_pkg::res_t e;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat kind %0d sector %0h", k, s));
        return;
      end
      e = expected_beats.pop_front();
      if (k === smwb_pkg::KIND_DONE) dones_seen++;
      else flushes_seen++;
      if (k !== e.kind || s !== e.sector || l !== e.length || st !== e.status ||
          lst !== e.last)
        report($sformatf("got %0d/%0h/%0d/%0d/%0d want %0d/%0h/%0d/%0d/%0d",
                         k, s, l, st, lst, e.kind, e.sector, e.length, e.status,
                         e.last));
    endtask
  endclass

  wbuf_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    hold_req;
  int unsigned    burst_left;
  bit [smwb_pkg::SectorW-1:0] next_sec;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on cycles in which no beat moves.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("watchdog expired with %0d beats outstanding",
                 sb.expected_beats.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: stalls on a pattern of its own, or holds off on request.
  initial begin
    int unsigned phase;
    phase = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        sb.check_result(kind_o, flush_sector_o, flush_length_o, status_o, last_o);
      @(negedge clk_i);
      phase++;
      if (hold_req > 0) begin
        hold_req--;
        pop = 1'b0;
      end else if (phase % 256 < 64) begin
        pop = 1'b1;
      end else begin
        pop = (phase % 7 != 3) && ($urandom_range(0, 3) != 0);
      end
    end
  end

  // One input beat, offered until taken; gaps fall between random bursts.
  task automatic send_item(smwb_pkg::func_e f, bit [smwb_pkg::SectorW-1:0] s,
                           bit [smwb_pkg::LenW-1:0] c);
    bit taken;
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    push           = 1'b1;
    func_i         = f;
    start_sector_i = s;
    sector_count_i = c;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !full;
      @(negedge clk_i);
    end
    sb.note_input(f, s, c);
    items_sent++;
    if (f == smwb_pkg::FUNC_WRITE && c != 0) next_sec = s + c;
  endtask

  // Let the block drain, then write one register.
  task automatic write_reg(smwb_pkg::reg_e r, bit [smwb_pkg::LenW-1:0] v);
    push = 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = r;
    cfg_data_i  = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(r, v);
  endtask

  // A random item, mostly well-formed write streams and reads that hit the table.
  task automatic random_item();
    int unsigned   pick;
    bit [smwb_pkg::LenW-1:0] c;
    bit [smwb_pkg::SectorW-1:0] s;
    int unsigned   top;
    pick = $urandom_range(0, 99);
    top  = (sb.capacity / 4 > 0) ? sb.capacity / 4 : 1;
    c    = ($urandom_range(0, 19) == 0) ? smwb_pkg::LenW'($urandom)
                                        : smwb_pkg::LenW'($urandom_range(1, top));
    if (pick < 45) begin
      send_item(smwb_pkg::FUNC_WRITE, next_sec, c);
    end else if (pick < 58) begin
      send_item(smwb_pkg::FUNC_WRITE, smwb_pkg::SectorW'($urandom), c);
    end else if (pick < 78) begin
      if (sb.n_ext > 0) s = sb.ext_start[$urandom_range(0, sb.n_ext - 1)]
                            + smwb_pkg::SectorW'($urandom_range(0, 3))
                            - smwb_pkg::SectorW'($urandom_range(0, 3));
      else s = next_sec;
      send_item(smwb_pkg::FUNC_READ, s, smwb_pkg::LenW'($urandom_range(0, 40)));
    end else if (pick < 84) begin
      send_item(smwb_pkg::FUNC_READ, smwb_pkg::SectorW'($urandom),
                smwb_pkg::LenW'($urandom));
    end else if (pick < 89) begin
      send_item(smwb_pkg::FUNC_FLUSH, smwb_pkg::SectorW'($urandom),
                smwb_pkg::LenW'($urandom));
    end else if (pick < 92) begin
      send_item(smwb_pkg::FUNC_NONE, smwb_pkg::SectorW'($urandom),
                smwb_pkg::LenW'($urandom));
    end else if (pick < 95) begin
      send_item(smwb_pkg::FUNC_WRITE, smwb_pkg::SectorW'($urandom), '0);
    end else begin
      send_item(smwb_pkg::FUNC_WRITE, next_sec,
                smwb_pkg::LenW'($urandom_range(sb.capacity, 65535)));
    end
  endtask

  // Main sequence.
  initial begin
    bit [smwb_pkg::LenW-1:0] caps[5];
    bit [smwb_pkg::LenW-1:0] merges[5];
    sb = new();
    items_sent = 0;
    hold_req   = 0;
    burst_left = 0;
    next_sec   = 31'h100;
    rst_ni = 1'b0;
    push = 1'b0;
    func_i = smwb_pkg::FUNC_WRITE;
    start_sector_i = '0;
    sector_count_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = smwb_pkg::REG_BUFFER_SECTORS;
    cfg_data_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings.
    send_item(smwb_pkg::FUNC_WRITE, 31'h100, '0);
    send_item(smwb_pkg::FUNC_WRITE, 31'h100, 16'd1025);
    send_item(smwb_pkg::FUNC_WRITE, 31'h100, 16'd8);
    send_item(smwb_pkg::FUNC_WRITE, 31'h108, 16'd8);
    send_item(smwb_pkg::FUNC_READ, 31'h10F, 16'd1);
    send_item(smwb_pkg::FUNC_READ, 31'h0, '0);
    send_item(smwb_pkg::FUNC_NONE, 31'h7FFFFFFF, 16'hFFFF);
    for (int i = 0; i < 17; i++)
      send_item(smwb_pkg::FUNC_WRITE, smwb_pkg::SectorW'(i * 64), 16'd2);
    send_item(smwb_pkg::FUNC_WRITE, 31'h7FFFFFF0, 16'd16);
    send_item(smwb_pkg::FUNC_WRITE, 31'h0, 16'd4);
    send_item(smwb_pkg::FUNC_READ, 31'h7FFFFFFF, 16'hFFFF);
    send_item(smwb_pkg::FUNC_WRITE, 31'h7FFFFFFF, 16'd1024);
    send_item(smwb_pkg::FUNC_FLUSH, 31'h0, '0);

    // Random phases over several register settings, extremes among them.
    caps   = '{16'd1024, 16'd1, 16'd65535, 16'd40, 16'd300};
    merges = '{16'd1024, 16'd1, 16'd65535, 16'd12, 16'd65535};
    for (int p = 0; p < 5; p++) begin
      write_reg(smwb_pkg::REG_BUFFER_SECTORS, caps[p]);
      write_reg(smwb_pkg::REG_MAX_MERGE, merges[p]);
      if (p == 2) hold_req = 400;
      for (int k = 0; k < 100; k++) random_item();
    end

    push = 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
    $display("%0d items sent over five register settings; %0d flushes and %0d dones checked",
             items_sent, sb.flushes_seen, sb.dones_seen);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d beats missing", sb.errors, sb.expected_beats.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/smwb_pkg.sv
hw/rtl/smwb_front.sv
hw/rtl/smwb_back.sv
hw/rtl/ssd_merging_write_buffer.sv
tb/ssd_merging_write_buffer_tb.sv
